@@ hdl/adc_frame_loss_tracker_macros.svh @@
// Assertion macros used by the asserting file of the frame loss tracker.
`ifndef ADC_FRAME_LOSS_TRACKER_MACROS_SVH
`define ADC_FRAME_LOSS_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AFLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AFLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/aflt_pkg.sv @@
package aflt_pkg;

    localparam int NUM_INSTRUMENTS = 4;
    localparam int INST_W          = 2;
    localparam int PTR_W           = 11;
    localparam int MOVE_W          = PTR_W + 1;
    localparam int RING_SIZE       = 2048;
    localparam int FRAME_SAMPLES   = 64;
    localparam int FS_SHIFT        = 6;
    localparam int BLOCK_FRAMES    = 8;
    localparam int SAVE_BUFFERS    = 4;
    localparam int SAVE_SLOTS      = BLOCK_FRAMES * SAVE_BUFFERS;
    localparam int LOST_ENTRIES    = 32;
    localparam int LE_W            = 5;
    localparam int TABLE_DEPTH     = NUM_INSTRUMENTS * LOST_ENTRIES;
    localparam int TAB_W           = INST_W + LE_W;
    localparam int FN_W            = 32;
    localparam int STAMP_W         = 32;
    localparam int RETRY_W         = 8;
    localparam int RETRY_MAX       = 255;
    localparam int LOST_W          = 5;
    localparam int SLOT_W          = 5;
    localparam int FB_W            = 2;
    localparam int MASK_W          = 4;
    localparam int CFG_ADDR_W      = 1;
    localparam int CFG_DATA_W      = 8;
    localparam int ENTRY_W         = PTR_W + FN_W + STAMP_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_RETRY_LIMIT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NOISE_MASK  = 1'b1;

    typedef struct packed {
        logic [INST_W-1:0] instrument;
        logic [PTR_W-1:0]  data_pointer;
    } t_in_word;

    typedef struct packed {
        logic              is_retransmission;
        logic [LOST_W-1:0] lost_added;
        logic              save_valid;
        logic [SLOT_W-1:0] save_slot;
        logic              flush;
        logic [FB_W-1:0]   flush_buffer;
        logic              table_overflow;
    } t_out_word;

endpackage

@@ hdl/adc_frame_loss_tracker.sv @@
// The result word is offered once the sequencer has made the aging and lookup pass
// and, for a gap, one further pass per missing frame of the gap (0 to 31).
// Throughput: one word at a time; each table pass walks the entries through the single
// read port of the lost-table memory, and the input also stalls while a result waits.
// Reset: synchronous, active low; clears counters, pointers, valid bits and
// restores retry_limit to 3 and noise_mask to 0. Table contents need no reset.
module adc_frame_loss_tracker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [aflt_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [aflt_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                               i_in_valid,
    input  aflt_pkg::t_in_word                 i_in_data,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output aflt_pkg::t_out_word                o_out_data,
    input  logic                               i_out_stall
);

    // The sequencer walks one instrument's slice of the lost table with a single
    // compare unit. The first pass ages entries and looks for the incoming
    // pointer; each missing frame of a gap then gets its own pass that looks
    // for an entry with the same key and for the first free entry.
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN0  = 6'b000010,
        S_DECIDE = 6'b000100,
        S_GAP    = 6'b001000,
        S_GAP_WR = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state r_state;
    logic   r_res_ready;

    // Configuration registers.
    logic [aflt_pkg::RETRY_W-1:0] r_retry_limit;
    logic [aflt_pkg::MASK_W-1:0]  r_noise_mask;

    // Per-instrument state.
    logic [aflt_pkg::FN_W-1:0]  r_frame_number [aflt_pkg::NUM_INSTRUMENTS];
    logic [aflt_pkg::PTR_W-1:0] r_last_pointer [aflt_pkg::NUM_INSTRUMENTS];
    logic [aflt_pkg::FB_W-1:0]  r_next_buf     [aflt_pkg::NUM_INSTRUMENTS];

    // Lost-table valid bits. Key, frame number and write stamp live in RAM.
    // Every word adds one retry to every live entry, so an entry's retry count
    // is the number of words finished since it was written. Retries stop at
    // 255 and the limit never exceeds 255, so the unsaturated count compares
    // against the limit the same way.
    logic [aflt_pkg::TABLE_DEPTH-1:0] r_lv;
    logic [aflt_pkg::STAMP_W-1:0]     r_step;

    // Working registers of the word in flight.
    logic [aflt_pkg::INST_W-1:0] r_inst;
    logic [aflt_pkg::PTR_W-1:0]  r_ptr;
    logic [aflt_pkg::FN_W-1:0]   r_fn;
    logic [aflt_pkg::PTR_W-1:0]  r_key;
    logic [aflt_pkg::LOST_W-1:0] r_gap_left;
    logic [aflt_pkg::LOST_W-1:0] r_added;
    logic                        r_ovf;
    logic                        r_retx;
    logic                        r_hit;
    logic [aflt_pkg::LE_W-1:0]   r_hit_idx;
    logic [aflt_pkg::FN_W-1:0]   r_hit_fn;
    logic                        r_found;
    logic [aflt_pkg::LE_W-1:0]   r_found_idx;
    logic                        r_free;
    logic [aflt_pkg::LE_W-1:0]   r_free_idx;

    // Scan pointer: r_rd_idx issues RAM reads, r_cmp_idx tracks the data.
    logic [aflt_pkg::LE_W:0]     r_rd_idx;
    logic                        r_cmp_en;
    logic [aflt_pkg::LE_W-1:0]   r_cmp_idx;

    aflt_pkg::t_out_word r_res;

    logic                             in_accept;
    logic [aflt_pkg::TAB_W-1:0]       cmp_addr;
    logic [aflt_pkg::ENTRY_W-1:0]     ram_rdata;
    logic [aflt_pkg::PTR_W-1:0]       ent_key;
    logic [aflt_pkg::FN_W-1:0]        ent_fn;
    logic [aflt_pkg::STAMP_W-1:0]     ent_stamp;
    logic [aflt_pkg::STAMP_W-1:0]     ent_age;
    logic                             ent_valid;
    logic                             block_edge;
    logic                             age_kill;
    logic                             scan_last;
    logic                             ram_we;
    logic [aflt_pkg::LE_W-1:0]        wr_idx;
    logic [aflt_pkg::PTR_W-1:0]       prev_ptr;
    logic [aflt_pkg::MOVE_W-1:0]      move;
    logic [aflt_pkg::LOST_W:0]        lost_raw;
    logic [aflt_pkg::LOST_W-1:0]      lost;
    logic [aflt_pkg::FN_W-1:0]        slot_base;
    logic                             noise;
    logic                             fin_flush;

    // A finished result that has not yet moved to the output register holds
    // the input off, so no accepted word can be dropped.
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_res_ready;

    assign cmp_addr  = {r_inst, r_cmp_idx};
    assign ent_key   = ram_rdata[aflt_pkg::ENTRY_W-1:aflt_pkg::FN_W+aflt_pkg::STAMP_W];
    assign ent_fn    = ram_rdata[aflt_pkg::FN_W+aflt_pkg::STAMP_W-1:aflt_pkg::STAMP_W];
    assign ent_stamp = ram_rdata[aflt_pkg::STAMP_W-1:0];
    assign ent_age   = r_step - ent_stamp;
    assign ent_valid = r_lv[cmp_addr];
    assign scan_last = r_cmp_en && (r_cmp_idx == aflt_pkg::LE_W'(aflt_pkg::LOST_ENTRIES - 1));

    // Aging: a block boundary past the first block retires entries older than
    // one block; an entry whose retries reached the limit goes in any case.
    assign block_edge = ((r_fn % aflt_pkg::BLOCK_FRAMES) == 0)
                        && (r_fn > aflt_pkg::FN_W'(aflt_pkg::BLOCK_FRAMES));
    assign age_kill   = ent_valid && ((ent_age >= aflt_pkg::STAMP_W'(r_retry_limit))
                        || (block_edge && (ent_fn < r_fn - aflt_pkg::FN_W'(aflt_pkg::BLOCK_FRAMES))));

    // Gap size. A pointer equal to the last one counts as a full ring wrap.
    assign prev_ptr = r_last_pointer[r_inst];
    assign move     = (r_ptr > prev_ptr)
                      ? ({1'b0, r_ptr} - {1'b0, prev_ptr})
                      : (aflt_pkg::MOVE_W'(aflt_pkg::RING_SIZE) + {1'b0, r_ptr} - {1'b0, prev_ptr});
    assign lost_raw = (aflt_pkg::LOST_W + 1)'(move >> aflt_pkg::FS_SHIFT);
    assign lost     = (lost_raw != 0) ? aflt_pkg::LOST_W'(lost_raw - 1'b1) : '0;

    // An existing entry with the same key wins over a free entry.
    assign wr_idx = r_found ? r_found_idx : r_free_idx;
    assign ram_we = (r_state == S_GAP_WR) && (r_found || r_free);

    assign noise     = r_noise_mask[r_inst];
    assign slot_base = (r_retx ? r_hit_fn : r_fn) - 1'b1;
    assign fin_flush = !noise && ((r_fn % aflt_pkg::BLOCK_FRAMES) == 0);

    aflt_ram #(
        .WIDTH (aflt_pkg::ENTRY_W),
        .DEPTH (aflt_pkg::TABLE_DEPTH),
        .ADDR_W(aflt_pkg::TAB_W)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr({r_inst, wr_idx}),
        .i_wdata({r_key, r_fn, r_step}),
        .i_raddr({r_inst, r_rd_idx[aflt_pkg::LE_W-1:0]}),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_res_ready   <= 1'b0;
            o_out_valid   <= 1'b0;
            r_retry_limit <= aflt_pkg::RETRY_W'(3);
            r_noise_mask  <= '0;
            r_lv          <= '0;
            r_step        <= '0;
            r_cmp_en      <= 1'b0;
            r_rd_idx      <= '0;
            for (int i = 0; i < aflt_pkg::NUM_INSTRUMENTS; i++) begin
                r_frame_number[i] <= '0;
                r_last_pointer[i] <= '0;
                r_next_buf[i]     <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    aflt_pkg::CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_wdata;
                    aflt_pkg::CFG_NOISE_MASK:  r_noise_mask  <= i_cfg_wdata[aflt_pkg::MASK_W-1:0];
                    default: ;
                endcase
            end

            // The result register frees as soon as the far side takes it.
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            if (r_res_ready && (!o_out_valid || !i_out_stall)) begin
                o_out_data  <= r_res;
                o_out_valid <= 1'b1;
                r_res_ready <= 1'b0;
            end

            // Shared scan counter for both kinds of pass.
            if (r_state == S_SCAN0 || r_state == S_GAP) begin
                if (!r_rd_idx[aflt_pkg::LE_W]) begin
                    r_rd_idx  <= r_rd_idx + 1'b1;
                    r_cmp_en  <= 1'b1;
                    r_cmp_idx <= r_rd_idx[aflt_pkg::LE_W-1:0];
                end else begin
                    r_cmp_en <= 1'b0;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept && !r_res_ready) begin
                        r_inst   <= i_in_data.instrument;
                        r_ptr    <= i_in_data.data_pointer;
                        r_fn     <= r_frame_number[i_in_data.instrument] + 1'b1;
                        r_added  <= '0;
                        r_ovf    <= 1'b0;
                        r_retx   <= 1'b0;
                        r_hit    <= 1'b0;
                        r_rd_idx <= '0;
                        r_cmp_en <= 1'b0;
                        r_state  <= S_SCAN0;
                    end
                end
                S_SCAN0: begin
                    if (r_cmp_en) begin
                        if (age_kill) begin
                            r_lv[cmp_addr] <= 1'b0;
                        end else if (ent_valid && (ent_key == r_ptr) && !r_hit) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_cmp_idx;
                            r_hit_fn  <= ent_fn;
                        end
                    end
                    if (scan_last) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_fn == aflt_pkg::FN_W'(1)) begin
                        r_last_pointer[r_inst] <= r_ptr;
                        r_state                <= S_FINISH;
                    end else if (r_hit) begin
                        // Retransmission: the frame goes back to its old slot.
                        r_retx                    <= 1'b1;
                        r_fn                      <= r_fn - 1'b1;
                        r_lv[{r_inst, r_hit_idx}] <= 1'b0;
                        r_state                   <= S_FINISH;
                    end else begin
                        r_last_pointer[r_inst] <= r_ptr;
                        r_key      <= prev_ptr + aflt_pkg::PTR_W'(aflt_pkg::FRAME_SAMPLES);
                        r_gap_left <= lost;
                        r_found    <= 1'b0;
                        r_free     <= 1'b0;
                        r_rd_idx   <= '0;
                        r_cmp_en   <= 1'b0;
                        r_state    <= (lost == 0) ? S_FINISH : S_GAP;
                    end
                end
                S_GAP: begin
                    if (r_cmp_en) begin
                        if (ent_valid && (ent_key == r_key) && !r_found) begin
                            r_found     <= 1'b1;
                            r_found_idx <= r_cmp_idx;
                        end
                        if (!ent_valid && !r_free) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_cmp_idx;
                        end
                    end
                    if (scan_last) begin
                        r_state <= S_GAP_WR;
                    end
                end
                S_GAP_WR: begin
                    if (r_found || r_free) begin
                        r_lv[{r_inst, wr_idx}] <= 1'b1;
                        if (r_added != aflt_pkg::LOST_W'(31)) begin
                            r_added <= r_added + 1'b1;
                        end
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    // Every missing frame advances the count, stored or dropped.
                    r_fn       <= r_fn + 1'b1;
                    r_key      <= r_key + aflt_pkg::PTR_W'(aflt_pkg::FRAME_SAMPLES);
                    r_gap_left <= r_gap_left - 1'b1;
                    r_found    <= 1'b0;
                    r_free     <= 1'b0;
                    r_rd_idx   <= '0;
                    r_cmp_en   <= 1'b0;
                    r_state    <= (r_gap_left == aflt_pkg::LOST_W'(1)) ? S_FINISH : S_GAP;
                end
                S_FINISH: begin
                    r_frame_number[r_inst]  <= r_fn;
                    r_step                  <= r_step + 1'b1;
                    r_res.is_retransmission <= r_retx;
                    r_res.lost_added        <= r_added;
                    r_res.table_overflow    <= r_ovf;
                    r_res.save_valid        <= !noise;
                    r_res.save_slot         <= noise ? '0
                        : aflt_pkg::SLOT_W'(slot_base % aflt_pkg::SAVE_SLOTS);
                    r_res.flush             <= fin_flush;
                    r_res.flush_buffer      <= fin_flush ? r_next_buf[r_inst] : '0;
                    if (fin_flush) begin
                        r_next_buf[r_inst] <=
                            (r_next_buf[r_inst] == aflt_pkg::FB_W'(aflt_pkg::SAVE_BUFFERS - 1))
                            ? '0 : r_next_buf[r_inst] + 1'b1;
                    end
                    r_res_ready <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`include "adc_frame_loss_tracker_macros.svh"

    // An accepted word always starts the aging and lookup pass.
    `AFLT_ASSERT_NEXT(a_accept_starts_scan, i_clk, i_rst_n, in_accept && !r_res_ready, r_state == S_SCAN0)
    // A retransmission never records a gap.
    `AFLT_ASSERT_NOW(a_retx_no_gap, i_clk, i_rst_n, o_out_valid && o_out_data.is_retransmission, o_out_data.lost_added == 0 && !o_out_data.table_overflow)
    // A flush only accompanies a saved frame.
    `AFLT_ASSERT_NOW(a_flush_saved, i_clk, i_rst_n, o_out_valid && o_out_data.flush, o_out_data.save_valid)

endmodule

@@ hdl/aflt_ram.sv @@
module aflt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
